// ===== rtl/core/led_mbc_pkg.sv =====
`default_nettype none

package led_mbc_pkg;

	localparam int MODE_W     = 6;
	localparam int CMD_W      = 8;
	localparam int HALF_W     = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// mode bit positions
	localparam int B_ON      = 0;
	localparam int B_OFF     = 1;
	localparam int B_BLINK   = 2;
	localparam int B_UNBLINK = 3;
	localparam int B_SLOW    = 4;
	localparam int B_FAST    = 5;

	localparam logic [MODE_W-1:0] BLINK_ANY  = 6'b110100;
	localparam logic [MODE_W-1:0] MODE_RESET = 6'b000010;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 8'd3;

	localparam logic [HALF_W-1:0] NORMAL_RESET = 16'd50;
	localparam logic [HALF_W-1:0] SLOW_RESET   = 16'd500;
	localparam logic [HALF_W-1:0] FAST_RESET   = 16'd167;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_LIGHT = 2'd1,
		PEND_DARK  = 2'd2
	} pend_t;

	typedef struct packed {
		logic              invert_drive;
		logic [HALF_W-1:0] normal_half_ms;
		logic [HALF_W-1:0] slow_half_ms;
		logic [HALF_W-1:0] fast_half_ms;
	} cfg_t;

	typedef struct packed {
		logic             operation;
		logic [CMD_W-1:0] command_bits;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/core/led_mbc_cfg.sv =====
`default_nettype none

module led_mbc_cfg (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [led_mbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [led_mbc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output led_mbc_pkg::cfg_t                    cfg
);

	led_mbc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_drive   <= 1'b0;
			cfg_q.normal_half_ms <= led_mbc_pkg::NORMAL_RESET;
			cfg_q.slow_half_ms   <= led_mbc_pkg::SLOW_RESET;
			cfg_q.fast_half_ms   <= led_mbc_pkg::FAST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				led_mbc_pkg::CFG_INVERT: cfg_q.invert_drive   <= cfg_data[0];
				led_mbc_pkg::CFG_NORMAL: cfg_q.normal_half_ms <= cfg_data;
				led_mbc_pkg::CFG_SLOW:   cfg_q.slow_half_ms   <= cfg_data;
				led_mbc_pkg::CFG_FAST:   cfg_q.fast_half_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/led_mbc_in.sv =====
`default_nettype none

module led_mbc_in (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cmd_valid,
	output logic                              cmd_stall,
	input  wire                               operation,
	input  wire  [led_mbc_pkg::CMD_W-1:0]     command_bits,
	input  wire                               out_free,
	output logic                              fire,
	output led_mbc_pkg::item_t                item
);

	logic               valid_s1;
	led_mbc_pkg::item_t item_s1;

	assign fire      = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign item      = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1.operation    <= operation;
			item_s1.command_bits <= command_bits;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/led_mbc_step.sv =====
`default_nettype none

module led_mbc_step #(
	parameter int COUNT_BITS = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               fire,
	input  led_mbc_pkg::item_t                item,
	input  led_mbc_pkg::cfg_t                 cfg,
	input  wire                               res_stall,
	output logic                              out_free,
	output logic                              res_valid,
	output logic                              rejected,
	output logic [led_mbc_pkg::MODE_W-1:0]    mode_bits,
	output logic                              pin_level
);

	logic [led_mbc_pkg::MODE_W-1:0] mode_q, mode_d;
	logic                           lit_q, lit_d;
	led_mbc_pkg::pend_t             pend_q, pend_d;
	logic [COUNT_BITS-1:0]          cnt_q, cnt_d;
	logic [COUNT_BITS-1:0]          half_q, half_d;

	logic                           res_valid_q;
	logic                           rejected_q;
	logic [led_mbc_pkg::MODE_W-1:0] mode_bits_q;
	logic                           pin_level_q;

	logic [led_mbc_pkg::MODE_W-1:0] v;
	logic                           rej;
	logic [led_mbc_pkg::HALF_W-1:0] half_sel;
	logic [COUNT_BITS-1:0]          half_clip;
	logic [COUNT_BITS-1:0]          cnt_dec;

	assign v   = item.command_bits[led_mbc_pkg::MODE_W-1:0];
	assign rej = (v[led_mbc_pkg::B_ON] && v[led_mbc_pkg::B_OFF]) ||
		((|(v & led_mbc_pkg::BLINK_ANY)) && v[led_mbc_pkg::B_UNBLINK]);

	// last blink kind in the order normal, slow, fast wins
	always_comb begin
		priority if (v[led_mbc_pkg::B_FAST]) begin
			half_sel = cfg.fast_half_ms;
		end else if (v[led_mbc_pkg::B_SLOW]) begin
			half_sel = cfg.slow_half_ms;
		end else begin
			half_sel = cfg.normal_half_ms;
		end
	end

	// saturate to the counter range
	if (COUNT_BITS >= led_mbc_pkg::HALF_W) begin : g_wide
		assign half_clip = COUNT_BITS'(half_sel);
	end else begin : g_narrow
		assign half_clip = (|half_sel[led_mbc_pkg::HALF_W-1:COUNT_BITS]) ?
			{COUNT_BITS{1'b1}} : half_sel[COUNT_BITS-1:0];
	end

	assign cnt_dec = (cnt_q != '0) ? (cnt_q - COUNT_BITS'(1)) : '0;

	always_comb begin
		mode_d = mode_q;
		lit_d  = lit_q;
		pend_d = pend_q;
		cnt_d  = cnt_q;
		half_d = half_q;
		if (item.operation == led_mbc_pkg::OP_COMMAND) begin
			if (!rej) begin
				mode_d = mode_q | v;
				if (v[led_mbc_pkg::B_ON]) begin
					lit_d = 1'b1;
					mode_d[led_mbc_pkg::B_OFF] = 1'b0;
				end
				if (v[led_mbc_pkg::B_OFF]) begin
					lit_d = 1'b0;
					mode_d[led_mbc_pkg::B_ON] = 1'b0;
				end
				if (|(v & led_mbc_pkg::BLINK_ANY)) begin
					half_d = half_clip;
					lit_d  = mode_d[led_mbc_pkg::B_ON];
					pend_d = mode_d[led_mbc_pkg::B_ON] ?
						led_mbc_pkg::PEND_DARK : led_mbc_pkg::PEND_LIGHT;
					cnt_d  = half_clip;
					mode_d[led_mbc_pkg::B_UNBLINK] = 1'b0;
				end
				if (v[led_mbc_pkg::B_UNBLINK]) begin
					pend_d = led_mbc_pkg::PEND_NONE;
					cnt_d  = '0;
					lit_d  = mode_d[led_mbc_pkg::B_ON];
					mode_d = mode_d & ~led_mbc_pkg::BLINK_ANY;
				end
			end
		end else begin
			unique case (pend_q)
				led_mbc_pkg::PEND_LIGHT,
				led_mbc_pkg::PEND_DARK: begin
					if (cnt_dec == '0) begin
						lit_d  = (pend_q == led_mbc_pkg::PEND_LIGHT);
						pend_d = (pend_q == led_mbc_pkg::PEND_LIGHT) ?
							led_mbc_pkg::PEND_DARK : led_mbc_pkg::PEND_LIGHT;
						cnt_d  = half_q;
					end else begin
						cnt_d = cnt_dec;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= led_mbc_pkg::MODE_RESET;
			lit_q  <= 1'b0;
			pend_q <= led_mbc_pkg::PEND_NONE;
			cnt_q  <= '0;
			half_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			lit_q  <= lit_d;
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
			half_q <= half_d;
		end
	end

	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && out_free) begin
			rejected_q  <= (item.operation == led_mbc_pkg::OP_COMMAND) && rej;
			mode_bits_q <= mode_d;
			pin_level_q <= cfg.invert_drive ? lit_d : !lit_d;
		end
	end

	assign res_valid = res_valid_q;
	assign rejected  = rejected_q;
	assign mode_bits = mode_bits_q;
	assign pin_level = pin_level_q;

endmodule

`default_nettype wire

// ===== rtl/core/led_mode_blink_controller.sv =====
// an accepted command or tick yields one result word
// throughput: one word per cycle while res_stall is low, set by the single state update stage
// input register, then state update and result register in one pass
// reset: asynchronous, active low; lit state dark, off mode kept, no toggle pending
// registers return to invert 0 and half periods 50, 500 and 167 ticks
`default_nettype none

module led_mode_blink_controller #(
	parameter int COUNT_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cmd_valid,
	output logic                                cmd_stall,
	input  wire                                 operation,
	input  wire  [led_mbc_pkg::CMD_W-1:0]       command_bits,
	output logic                                res_valid,
	input  wire                                 res_stall,
	output logic                                rejected,
	output logic [led_mbc_pkg::MODE_W-1:0]      mode_bits,
	output logic                                pin_level,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [led_mbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [led_mbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	led_mbc_pkg::cfg_t  cfg;
	led_mbc_pkg::item_t item;
	logic               fire;
	logic               out_free;

	led_mbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	led_mbc_in u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.operation    (operation),
		.command_bits (command_bits),
		.out_free     (out_free),
		.fire         (fire),
		.item         (item)
	);

	led_mbc_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item),
		.cfg       (cfg),
		.res_stall (res_stall),
		.out_free  (out_free),
		.res_valid (res_valid),
		.rejected  (rejected),
		.mode_bits (mode_bits),
		.pin_level (pin_level)
	);

endmodule

`default_nettype wire

// ===== rtl/core/led_mbc_checker.sv =====
`default_nettype none

module led_mbc_props (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              res_valid,
	input wire                              res_stall,
	input wire                              rejected,
	input wire [led_mbc_pkg::MODE_W-1:0]    mode_bits,
	input wire                              pin_level
);

	// a held result word stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(rejected) &&
		$stable(mode_bits) && $stable(pin_level))
		else $error("result word changed while stalled");

	// on and off never kept together
	a_on_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(mode_bits[led_mbc_pkg::B_ON] && mode_bits[led_mbc_pkg::B_OFF]))
		else $error("on and off both kept");

	// unblink never kept alongside a blink kind
	a_unblink: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(mode_bits[led_mbc_pkg::B_UNBLINK] &&
		(mode_bits[led_mbc_pkg::B_BLINK] || mode_bits[led_mbc_pkg::B_SLOW] ||
		mode_bits[led_mbc_pkg::B_FAST])))
		else $error("unblink kept with a blink kind");

endmodule

bind led_mode_blink_controller led_mbc_props u_led_mbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.rejected  (rejected),
	.mode_bits (mode_bits),
	.pin_level (pin_level)
);

`default_nettype wire
